// ===== design/fcr_pkg.sv =====
`timescale 1ns / 1ps

package fcr_pkg;

  localparam logic [7:0] CharSoh  = 8'h01;
  localparam logic [7:0] CharEq   = 8'h3D;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // Number of characters in the replacement text.
  localparam int unsigned MaskLen = 10;
  localparam int unsigned BeatW   = 4;

  typedef enum logic [1:0] {
    EMIT_BYTE   = 2'd0,
    EMIT_MARK   = 2'd1,
    EMIT_REDACT = 2'd2
  } emit_kind_e;

  typedef struct packed {
    emit_kind_e  kind;
    logic [7:0]  data;
    logic        eom;
  } emit_t;

  function automatic logic [7:0] mask_char(input logic [BeatW-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = 8'h3C; // <
      4'd1: c = 8'h72; // r
      4'd2: c = 8'h65; // e
      4'd3: c = 8'h64; // d
      4'd4: c = 8'h61; // a
      4'd5: c = 8'h63; // c
      4'd6: c = 8'h74; // t
      4'd7: c = 8'h65; // e
      4'd8: c = 8'h64; // d
      4'd9: c = 8'h3E; // >
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/fcr_parser.sv =====
`timescale 1ns / 1ps

module fcr_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_message_i,
  output logic          emit_valid_o,
  output fcr_pkg::emit_t emit_o,
  input  logic          emit_ready_i
);

  localparam logic [1:0] PhStart  = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhPass   = 2'd2;
  localparam logic [1:0] PhDrop   = 2'd3;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eom_q;

  logic [1:0] phase_q, phase_d;
  logic [2:0] count_q, count_d;
  logic [9:0] tag_q, tag_d;

  logic       accept, advance, is_digit, present;
  logic [9:0] digit_val;
  fcr_pkg::emit_kind_e kind;

  assign in_ready_o = !s1_valid_q || emit_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign advance    = s1_valid_q && emit_ready_i;

  assign is_digit  = (s1_byte_q >= fcr_pkg::CharZero) && (s1_byte_q <= fcr_pkg::CharNine);
  assign digit_val = {6'd0, s1_byte_q[3:0]};

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    tag_d   = tag_q;
    present = 1'b1;
    kind    = fcr_pkg::EMIT_BYTE;
    if (s1_byte_q == fcr_pkg::CharSoh) begin
      phase_d = PhStart;
      count_d = 3'd0;
      tag_d   = 10'd0;
    end else begin
      case (phase_q)
        PhDrop: begin
          present = s1_eom_q;
          kind    = fcr_pkg::EMIT_MARK;
        end
        PhStart: begin
          if (s1_byte_q == fcr_pkg::CharZero) begin
            phase_d = PhStart;
          end else if (is_digit) begin
            phase_d = PhDigits;
            count_d = 3'd1;
            tag_d   = digit_val;
          end else begin
            phase_d = PhPass;
          end
        end
        PhDigits: begin
          if (is_digit) begin
            if (count_q >= 3'd3) begin
              count_d = 3'd4;
              phase_d = PhPass;
            end else begin
              count_d = count_q + 3'd1;
              // Only two digits are held here, so the product stays below 1024.
              tag_d   = (tag_q << 3) + (tag_q << 1) + digit_val;
            end
          end else if (s1_byte_q == fcr_pkg::CharEq && count_q == 3'd3 &&
                       (tag_q == 10'd553 || tag_q == 10'd554)) begin
            kind    = fcr_pkg::EMIT_REDACT;
            phase_d = PhDrop;
          end else begin
            phase_d = PhPass;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
    if (s1_eom_q) begin
      phase_d = PhStart;
      count_d = 3'd0;
      tag_d   = 10'd0;
    end
  end

  assign emit_valid_o = s1_valid_q && present;
  assign emit_o.kind  = kind;
  assign emit_o.data  = (kind == fcr_pkg::EMIT_MARK) ? 8'd0 : s1_byte_q;
  assign emit_o.eom   = s1_eom_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= PhStart;
      count_q    <= 3'd0;
      tag_q      <= 10'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        phase_q <= phase_d;
        count_q <= count_d;
        tag_q   <= tag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_eom_q  <= end_of_message_i;
    end
  end

endmodule

// ===== design/fcr_emitter.sv =====
`timescale 1ns / 1ps

module fcr_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           emit_valid_i,
  input  fcr_pkg::emit_t emit_i,
  output logic           emit_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           byte_valid_o,
  output logic           message_end_o,
  output logic           last_of_run_o
);

  localparam logic [fcr_pkg::BeatW-1:0] LastBeat = fcr_pkg::BeatW'(fcr_pkg::MaskLen);

  logic                      s2_valid_q;
  fcr_pkg::emit_t            s2_q;
  logic [fcr_pkg::BeatW-1:0] beat_q;
  logic                      last, xfer;

  assign last = (s2_q.kind != fcr_pkg::EMIT_REDACT) || (beat_q == LastBeat);
  assign xfer = s2_valid_q && out_ready_i;

  // The slot frees up on the transfer of the final beat of the held item.
  assign emit_ready_o = !s2_valid_q || (out_ready_i && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      beat_q     <= '0;
    end else if (emit_ready_o) begin
      s2_valid_q <= emit_valid_i;
      beat_q     <= '0;
    end else if (xfer) begin
      beat_q <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready_o && emit_valid_i) begin
      s2_q <= emit_i;
    end
  end

  always_comb begin
    case (s2_q.kind)
      fcr_pkg::EMIT_REDACT: begin
        out_byte_o = (beat_q == '0) ? s2_q.data : fcr_pkg::mask_char(beat_q - 1'b1);
      end
      fcr_pkg::EMIT_MARK: out_byte_o = 8'd0;
      default:            out_byte_o = s2_q.data;
    endcase
  end

  assign out_valid_o   = s2_valid_q;
  assign byte_valid_o  = (s2_q.kind != fcr_pkg::EMIT_MARK);
  assign message_end_o = s2_q.eom && last;
  assign last_of_run_o = last;

endmodule

// ===== design/fix_credential_redactor_core.sv =====
`timescale 1ns / 1ps
// Each byte is registered in the parser stage and then in the emitter stage.
// Throughput: one byte per cycle while out_ready_i is high; a credential '=' holds
// the output register for itself plus the replacement text, back-pressuring input.
// Reset (rst_ni, asynchronous, active low) empties both stages and returns the field
// parser to field start with no tag digits collected.
module fix_credential_redactor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       message_end_o,
  output logic       last_of_run_o
);

  logic           emit_valid, emit_ready;
  fcr_pkg::emit_t emit;

  fcr_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .emit_valid_o     (emit_valid),
    .emit_o           (emit),
    .emit_ready_i     (emit_ready)
  );

  fcr_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_valid_i  (emit_valid),
    .emit_i        (emit),
    .emit_ready_o  (emit_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .message_end_o (message_end_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
